### hw/rtl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal and centroid package
// Request and result types, internal widths and fixed constants shared by the
// triangle normal and centroid pipeline.
// ----------------------------------------------------------------------------
package tnc_pkg;

	localparam int TAG_W      = 16;
	localparam int COORD_W    = 32;
	localparam int UNIT_W     = 16;
	localparam int EDGE_W     = 33;
	localparam int PROD_W     = 66;
	localparam int CROSS_W    = 67;
	localparam int MAG_W      = 65;
	localparam int NORM_W     = 31;
	localparam int SQ_W       = 62;
	localparam int SUM_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int QUOT_W     = 15;
	localparam int NUM_W      = 46;
	localparam int CSUM_W     = 34;
	localparam int CABS_W     = 33;
	localparam int RECIP_W    = 35;
	localparam int CFULL_W    = 68;
	localparam int LZ_W       = 7;
	localparam int GROUPS     = 9;
	localparam int PAD_W      = GROUPS * 8;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int FRAC_BITS  = 14;

	// ceil(2^36 / 3): exact floor division by three for values below 2^35.
	localparam logic [RECIP_W-1:0] RECIP3       = 35'd22906492246;
	localparam int                 RECIP3_SHIFT = 36;
	localparam logic [QUOT_W-1:0]  UNIT_ONE     = 15'd16384;

	typedef struct packed {
		logic [TAG_W-1:0]          a_index;
		logic [TAG_W-1:0]          b_index;
		logic [TAG_W-1:0]          c_index;
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
	} tnc_req_t;

	typedef struct packed {
		logic [TAG_W-1:0]          tag_a;
		logic [TAG_W-1:0]          tag_b;
		logic [TAG_W-1:0]          tag_c;
		logic signed [COORD_W-1:0] centre_x;
		logic signed [COORD_W-1:0] centre_y;
		logic signed [COORD_W-1:0] centre_z;
		logic signed [UNIT_W-1:0]  unit_nx;
		logic signed [UNIT_W-1:0]  unit_ny;
		logic signed [UNIT_W-1:0]  unit_nz;
		logic                      degenerate;
	} tnc_res_t;

	// Data that rides alongside the normal computation.
	typedef struct packed {
		logic [2:0][TAG_W-1:0]   tag;
		logic [2:0][COORD_W-1:0] centre;
		logic [2:0]              neg;
		logic                    degenerate;
	} tnc_side_t;

endpackage

### hw/rtl/triangle_normal_centroid.sv
// ----------------------------------------------------------------------------
// Triangle normal and centroid
// Fully pipelined unit giving the rounded centroid and the Q1.14 unit face
// normal of one triangle per clock.
// ----------------------------------------------------------------------------
// The block accepts a new triangle request in every clock cycle and never
// pushes back: busy is held low, so a request is taken whenever start is high.
// Each request produces exactly one result, presented for a single cycle with
// done high; the receiver must capture it in that cycle. Most of the stages
// belong to the square root of the squared normal length, which retires one
// root bit per pipeline stage over 32 stages, followed by 15 stages of
// shift-subtract division that produce the normal components in parallel
// lanes. The remaining stages form edges, centroid sums and cross products,
// then normalise the cross product. Results leave in the order of their
// requests.
module triangle_normal_centroid
	import tnc_pkg::*;
#(
	parameter int INDEX_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tnc_req_t request,
	output logic     done,
	output tnc_res_t result
);

	localparam int               TAG_KEEP = (INDEX_WIDTH < TAG_W) ? INDEX_WIDTH : TAG_W;
	localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_KEEP) - 64'd1);
	// Clock edges from the edge that takes a request to the edge that takes
	// its result.
	localparam int               LATENCY  = 11 + SQRT_STEPS + DIV_STEPS + 1;

	// Returns the number of leading zeros of one byte (seven for zero).
	function automatic logic [2:0] lead8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd7;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) n = 3'(7 - k);
		end
		return n;
	endfunction

	// The pipeline never stalls, so requests are always welcome.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: edge vectors and centroid sums.
	// ------------------------------------------------------------------
	logic signed [COORD_W-1:0] va [3];
	logic signed [COORD_W-1:0] vb [3];
	logic signed [COORD_W-1:0] vc [3];
	logic signed [CSUM_W-1:0]  csum [3];
	logic [CSUM_W-1:0]         cmag [3];

	assign va[0] = request.a_x;
	assign va[1] = request.a_y;
	assign va[2] = request.a_z;
	assign vb[0] = request.b_x;
	assign vb[1] = request.b_y;
	assign vb[2] = request.b_z;
	assign vc[0] = request.c_x;
	assign vc[1] = request.c_y;
	assign vc[2] = request.c_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			csum[i] = CSUM_W'(va[i]) + CSUM_W'(vb[i]) + CSUM_W'(vc[i]);
			cmag[i] = csum[i][CSUM_W-1] ? CSUM_W'(-csum[i]) : CSUM_W'(csum[i]);
		end
	end

	logic                     v_s1;
	logic signed [EDGE_W-1:0] d_s1 [3];
	logic signed [EDGE_W-1:0] e_s1 [3];
	logic [CABS_W-1:0]        cx_s1 [3];
	logic [2:0]               cneg_s1;
	logic [2:0][TAG_W-1:0]    tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i]    <= EDGE_W'(vb[i]) - EDGE_W'(va[i]);
			e_s1[i]    <= EDGE_W'(vc[i]) - EDGE_W'(va[i]);
			// Adding one before the floor division rounds the mean to nearest.
			cx_s1[i]   <= CABS_W'(cmag[i] + 1'b1);
			cneg_s1[i] <= csum[i][CSUM_W-1];
		end
		tag_s1[0] <= request.a_index & TAG_MASK;
		tag_s1[1] <= request.b_index & TAG_MASK;
		tag_s1[2] <= request.c_index & TAG_MASK;
	end

	// ------------------------------------------------------------------
	// Stage 2: cross-product terms and reciprocal partial products.
	// ------------------------------------------------------------------
	logic                     v_s2;
	logic signed [PROD_W-1:0] pp_s2 [3];
	logic signed [PROD_W-1:0] pq_s2 [3];
	logic [51:0]              cph_s2 [3];
	logic [50:0]              cpl_s2 [3];
	logic [2:0]               cneg_s2;
	logic [2:0][TAG_W-1:0]    tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_s2[0] <= d_s1[1] * e_s1[2];
		pq_s2[0] <= d_s1[2] * e_s1[1];
		pp_s2[1] <= d_s1[2] * e_s1[0];
		pq_s2[1] <= d_s1[0] * e_s1[2];
		pp_s2[2] <= d_s1[0] * e_s1[1];
		pq_s2[2] <= d_s1[1] * e_s1[0];
		for (int i = 0; i < 3; i++) begin
			cph_s2[i] <= cx_s1[i][CABS_W-1:16] * RECIP3;
			cpl_s2[i] <= cx_s1[i][15:0] * RECIP3;
		end
		cneg_s2 <= cneg_s1;
		tag_s2  <= tag_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: cross product and finished centroid.
	// ------------------------------------------------------------------
	logic [CFULL_W-1:0] cfull [3];
	logic [COORD_W-1:0] cquot [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cfull[i] = {cph_s2[i], 16'b0} + CFULL_W'(cpl_s2[i]);
			cquot[i] = cfull[i][RECIP3_SHIFT +: COORD_W];
		end
	end

	logic                      v_s3;
	logic signed [CROSS_W-1:0] cross_s3 [3];
	tnc_side_t                 side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cross_s3[i]       <= CROSS_W'(pp_s2[i]) - CROSS_W'(pq_s2[i]);
			side_s3.centre[i] <= cneg_s2[i] ? -cquot[i] : cquot[i];
		end
		side_s3.tag        <= tag_s2;
		side_s3.neg        <= '0;
		side_s3.degenerate <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Stage 4: sign and magnitude of each cross component, and the degenerate flag.
	// ------------------------------------------------------------------
	logic             v_s4;
	logic [MAG_W-1:0] mag_s4 [3];
	tnc_side_t        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= cross_s3[i][CROSS_W-1] ? MAG_W'(-cross_s3[i]) : MAG_W'(cross_s3[i]);
			side_s4.neg[i] <= cross_s3[i][CROSS_W-1];
		end
		side_s4.tag        <= side_s3.tag;
		side_s4.centre     <= side_s3.centre;
		side_s4.degenerate <= (cross_s3[0] == '0) && (cross_s3[1] == '0) && (cross_s3[2] == '0);
	end

	// ------------------------------------------------------------------
	// Stages 5 to 7: leading-zero count of the combined magnitudes.
	// ------------------------------------------------------------------
	logic             v_s5;
	logic [MAG_W-1:0] mag_s5 [3];
	logic [MAG_W-1:0] orw_s5;
	tnc_side_t        side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		mag_s5  <= mag_s4;
		orw_s5  <= mag_s4[0] | mag_s4[1] | mag_s4[2];
		side_s5 <= side_s4;
	end

	logic [PAD_W-1:0] orw_pad;
	assign orw_pad = {(PAD_W - MAG_W)'(0), orw_s5};

	logic              v_s6;
	logic [MAG_W-1:0]  mag_s6 [3];
	logic [GROUPS-1:0] nz_s6;
	logic [2:0]        lzg_s6 [GROUPS];
	tnc_side_t         side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < GROUPS; j++) begin
			nz_s6[j]  <= orw_pad[PAD_W-1-8*j -: 8] != 8'd0;
			lzg_s6[j] <= lead8(orw_pad[PAD_W-1-8*j -: 8]);
		end
		mag_s6  <= mag_s5;
		side_s6 <= side_s5;
	end

	logic [LZ_W-1:0] lz_c;

	always_comb begin
		lz_c = '0;
		for (int j = GROUPS - 1; j >= 0; j--) begin
			if (nz_s6[j]) begin
				lz_c = LZ_W'(8 * j) + LZ_W'(lzg_s6[j]) - LZ_W'(PAD_W - MAG_W);
			end
		end
	end

	logic             v_s7;
	logic [MAG_W-1:0] mag_s7 [3];
	logic [LZ_W-1:0]  lz_s7;
	tnc_side_t        side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		mag_s7  <= mag_s6;
		lz_s7   <= lz_c;
		side_s7 <= side_s6;
	end

	// ------------------------------------------------------------------
	// Stage 8: shift so that the largest component has its top bit at 30.
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] shl [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shl[i] = mag_s7[i] << lz_s7;
		end
	end

	logic              v_s8;
	logic [NORM_W-1:0] m_s8 [3];
	tnc_side_t         side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s8[i] <= shl[i][MAG_W-1 -: NORM_W];
		end
		side_s8 <= side_s7;
	end

	// ------------------------------------------------------------------
	// Stage 9: squares of the normalised components.
	// ------------------------------------------------------------------
	logic              v_s9;
	logic [SQ_W-1:0]   sq_s9 [3];
	logic [NORM_W-1:0] m_s9 [3];
	tnc_side_t         side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s9[i] <= m_s8[i] * m_s8[i];
		end
		m_s9    <= m_s8;
		side_s9 <= side_s8;
	end

	// ------------------------------------------------------------------
	// Stage 10 and the square-root chain. Entry zero holds the sum of
	// squares; each following entry retires one bit of the root.
	// ------------------------------------------------------------------
	logic                           sq_v_s    [SQRT_STEPS+1];
	logic [SUM_W-1:0]               sq_rem_s  [SQRT_STEPS+1];
	logic [SUM_W-1:0]               sq_root_s [SQRT_STEPS+1];
	logic [2:0][NORM_W-1:0]         sq_m_s    [SQRT_STEPS+1];
	tnc_side_t                      sq_side_s [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else begin
			sq_v_s[0] <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= SUM_W'(sq_s9[0]) + SUM_W'(sq_s9[1]) + SUM_W'(sq_s9[2]);
		sq_root_s[0] <= '0;
		for (int i = 0; i < 3; i++) begin
			sq_m_s[0][i] <= m_s9[i];
		end
		sq_side_s[0] <= side_s9;
	end

	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * (k - 1));
		logic [SUM_W-1:0] trial;
		logic             ge;

		assign trial = sq_root_s[k-1] + BIT;
		assign ge    = sq_rem_s[k-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else begin
				sq_v_s[k] <= sq_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k]  <= ge ? sq_rem_s[k-1] - trial : sq_rem_s[k-1];
			sq_root_s[k] <= ge ? (sq_root_s[k-1] >> 1) + BIT : sq_root_s[k-1] >> 1;
			sq_m_s[k]    <= sq_m_s[k-1];
			sq_side_s[k] <= sq_side_s[k-1];
		end
	end

	// ------------------------------------------------------------------
	// Division chain: three lanes of m * 2^14 / L, rounded to nearest.
	// Entry zero holds the rounded numerator; each following entry
	// retires one quotient bit, most significant first.
	// ------------------------------------------------------------------
	logic [ROOT_W-1:0] root_len;
	assign root_len = sq_root_s[SQRT_STEPS][ROOT_W-1:0];

	logic                   dv_v_s   [DIV_STEPS+1];
	logic [2:0][NUM_W-1:0]  dv_rem_s [DIV_STEPS+1];
	logic [2:0][QUOT_W-1:0] dv_q_s   [DIV_STEPS+1];
	logic [ROOT_W-1:0]      dv_len_s [DIV_STEPS+1];
	tnc_side_t              dv_side_s[DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= sq_v_s[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= NUM_W'({sq_m_s[SQRT_STEPS][i], FRAC_BITS'(0)})
				+ NUM_W'(root_len >> 1);
		end
		dv_q_s[0]    <= '0;
		dv_len_s[0]  <= root_len;
		dv_side_s[0] <= sq_side_s[SQRT_STEPS];
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		localparam int SH = DIV_STEPS - j;
		logic [NUM_W:0] dvsr;
		logic [NUM_W:0] diff [3];
		logic [2:0]     ge;

		assign dvsr = (NUM_W + 1)'(dv_len_s[j-1]) << SH;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				diff[i] = {1'b0, dv_rem_s[j-1][i]} - dvsr;
				ge[i]   = {1'b0, dv_rem_s[j-1][i]} >= dvsr;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else begin
				dv_v_s[j] <= dv_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[j][i] <= ge[i] ? diff[i][NUM_W-1:0] : dv_rem_s[j-1][i];
				dv_q_s[j][i]   <= {dv_q_s[j-1][i][QUOT_W-2:0], ge[i]};
			end
			dv_len_s[j]  <= dv_len_s[j-1];
			dv_side_s[j] <= dv_side_s[j-1];
		end
	end

	// ------------------------------------------------------------------
	// Output register: clamp, sign and the degenerate case.
	// ------------------------------------------------------------------
	tnc_side_t               fin_side;
	logic [QUOT_W-1:0]       ncl [3];
	logic signed [UNIT_W-1:0] nsg [3];

	assign fin_side = dv_side_s[DIV_STEPS];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ncl[i] = (dv_q_s[DIV_STEPS][i] > UNIT_ONE) ? UNIT_ONE : dv_q_s[DIV_STEPS][i];
			if (fin_side.degenerate) begin
				nsg[i] = '0;
			end else if (fin_side.neg[i]) begin
				nsg[i] = -UNIT_W'(ncl[i]);
			end else begin
				nsg[i] = UNIT_W'(ncl[i]);
			end
		end
	end

	logic     done_q;
	tnc_res_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.tag_a      <= fin_side.tag[0];
		result_q.tag_b      <= fin_side.tag[1];
		result_q.tag_c      <= fin_side.tag[2];
		result_q.centre_x   <= fin_side.centre[0];
		result_q.centre_y   <= fin_side.centre[1];
		result_q.centre_z   <= fin_side.centre[2];
		result_q.unit_nx    <= nsg[0];
		result_q.unit_ny    <= nsg[1];
		result_q.unit_nz    <= nsg[2];
		result_q.degenerate <= fin_side.degenerate;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// Every request comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request did not complete after the pipeline latency");

	// A degenerate triangle reports a zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
			result.unit_nx == '0 && result.unit_ny == '0 && result.unit_nz == '0)
		else $error("degenerate result carries a non-zero normal");

	// Normalisation puts the largest square at or above 2^60.
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[0] && !sq_side_s[0].degenerate |-> sq_rem_s[0][SUM_W-1:60] != '0)
		else $error("normalised sum of squares is too small");

	// Since no component exceeds the length, no quotient exceeds one.
	a_quot: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[DIV_STEPS] && !fin_side.degenerate |->
			dv_q_s[DIV_STEPS][0] <= UNIT_ONE && dv_q_s[DIV_STEPS][1] <= UNIT_ONE &&
			dv_q_s[DIV_STEPS][2] <= UNIT_ONE)
		else $error("normal component quotient exceeds unit length");
`endif

endmodule
